@@ rtl/core/dufd_pkg.sv @@
package dufd_pkg;

	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned ADDR_W     = 16;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 8;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_HIGH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_LOW  = 1'd1;

	localparam logic [BYTE_W-1:0] HEADER_HIGH_RST = 8'h5A;
	localparam logic [BYTE_W-1:0] HEADER_LOW_RST  = 8'hA5;

	// payload byte positions that are captured
	localparam logic [BYTE_W-1:0] POS_CMD     = 8'd0;
	localparam logic [BYTE_W-1:0] POS_ADDR_HI = 8'd1;
	localparam logic [BYTE_W-1:0] POS_ADDR_LO = 8'd2;
	localparam logic [BYTE_W-1:0] POS_COUNT   = 8'd3;

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_HEAD,
		PH_LEN,
		PH_DATA
	} phase_t;

	typedef struct packed {
		logic [BYTE_W-1:0] command;
		logic [ADDR_W-1:0] address;
		logic [BYTE_W-1:0] word_count;
		logic [BYTE_W-1:0] payload_len;
	} res_t;

	// push side of the result queue
	typedef struct packed {
		logic push;
		res_t data;
	} res_push_t;

endpackage

@@ rtl/core/dufd_rx_if.sv @@
interface dufd_rx_if;
	import dufd_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);

endinterface

@@ rtl/core/dufd_res_if.sv @@
interface dufd_res_if;
	import dufd_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] command;
	logic [ADDR_W-1:0] address;
	logic [BYTE_W-1:0] word_count;
	logic [BYTE_W-1:0] payload_len;

	modport source (
		output valid, output command, output address, output word_count,
		output payload_len, input ready
	);
	modport sink (
		input valid, input command, input address, input word_count,
		input payload_len, output ready
	);

endinterface

@@ rtl/core/dufd_res_fifo.sv @@
module dufd_res_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  dufd_pkg::res_push_t wr,
	output logic                full,
	dufd_res_if.source          res
);
	import dufd_pkg::*;

	res_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign pop  = res.valid && res.ready;
	assign full = (cnt_q == 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr.push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)     rd_ptr_q <= ~rd_ptr_q;
			case ({wr.push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr.push) mem_q[wr_ptr_q] <= wr.data;
	end

	assign res.valid       = (cnt_q != 2'd0);
	assign res.command     = mem_q[rd_ptr_q].command;
	assign res.address     = mem_q[rd_ptr_q].address;
	assign res.word_count  = mem_q[rd_ptr_q].word_count;
	assign res.payload_len = mem_q[rd_ptr_q].payload_len;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr.push |-> cnt_q != 2'd2) else $error("result queue overflow");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("result queue count out of range");

	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 || cnt_q == 2'd2) |-> wr_ptr_q == rd_ptr_q)
		else $error("result queue pointers disagree with count");

endmodule

@@ rtl/core/display_uplink_frame_decoder.sv @@
// Deframer for a two-byte-header, length-prefixed uplink. Received bytes come in
// on rx, one per transfer; one byte can be taken every clock unless rx.ready is
// low, which happens only while the queue holds two results not yet taken. The
// block hunts for header_high followed by header_low (a wrong second byte sends
// it back to hunting, and that byte is not tried as a first header byte), then
// takes a length byte and that many payload bytes. When the last payload byte is
// taken, one result goes out on res: command (payload byte 0), address (bytes 1
// and 2, high first), word_count (byte 3) and payload_len. Bytes a short frame
// never carried read as zero; a length byte of zero drops the frame. The result
// is written into a two-entry queue at the edge that takes the last byte and is
// offered on res from the next cycle if the queue was empty. Header registers
// are written through cfg_wen/cfg_addr/cfg_wdata (index 0 header_high, index 1
// header_low); the user must do so only while the block is idle (not enforced).
module display_uplink_frame_decoder (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic [dufd_pkg::CFG_IDX_W-1:0]    cfg_addr,
	input  logic [dufd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	dufd_rx_if.sink                           rx,
	dufd_res_if.source                        res
);
	import dufd_pkg::*;

	// header registers
	logic [BYTE_W-1:0] hdr_hi_q;
	logic [BYTE_W-1:0] hdr_lo_q;

	// frame state
	phase_t            phase_q, phase_d;
	logic [BYTE_W-1:0] seen_q, seen_d;
	logic [BYTE_W-1:0] len_q, len_d;
	logic [BYTE_W-1:0] cmd_q, cmd_d;
	logic [ADDR_W-1:0] addr_q, addr_d;
	logic [BYTE_W-1:0] cnt_q, cnt_d;

	logic              take;
	logic              queue_full;
	logic [BYTE_W-1:0] b;
	logic [BYTE_W-1:0] seen_inc;
	res_push_t         wr;

	assign rx.ready = !queue_full;
	assign take     = rx.valid && rx.ready;
	assign b        = rx.rx_byte;
	assign seen_inc = seen_q + 8'd1;

	// configuration transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_hi_q <= HEADER_HIGH_RST;
			hdr_lo_q <= HEADER_LOW_RST;
		end else if (cfg_wen) begin
			case (cfg_addr)
				REG_HEADER_HIGH: hdr_hi_q <= cfg_wdata;
				REG_HEADER_LOW:  hdr_lo_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			seen_q  <= '0;
			len_q   <= '0;
			cmd_q   <= '0;
			addr_q  <= '0;
			cnt_q   <= '0;
		end else begin
			phase_q <= phase_d;
			seen_q  <= seen_d;
			len_q   <= len_d;
			cmd_q   <= cmd_d;
			addr_q  <= addr_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		seen_d  = seen_q;
		len_d   = len_q;
		cmd_d   = cmd_q;
		addr_d  = addr_q;
		cnt_d   = cnt_q;
		wr      = '0;
		if (take) begin
			case (phase_q)
				PH_HUNT: begin
					if (b == hdr_hi_q) phase_d = PH_HEAD;
				end
				PH_HEAD: begin
					phase_d = (b == hdr_lo_q) ? PH_LEN : PH_HUNT;
				end
				PH_LEN: begin
					// new frame: all captures start from zero
					seen_d = '0;
					cmd_d  = '0;
					addr_d = '0;
					cnt_d  = '0;
					if (b == '0) begin
						len_d   = '0;
						phase_d = PH_HUNT;
					end else begin
						len_d   = b;
						phase_d = PH_DATA;
					end
				end
				PH_DATA: begin
					case (seen_q)
						POS_CMD:     cmd_d = b;
						POS_ADDR_HI: addr_d = {b, addr_q[BYTE_W-1:0]};
						POS_ADDR_LO: addr_d = {addr_q[ADDR_W-1:BYTE_W], b};
						POS_COUNT:   cnt_d = b;
						default: ;   // later payload bytes are only counted
					endcase
					seen_d = seen_inc;
					if (seen_inc == len_q) begin
						// last byte: emit and clear for the next frame
						wr.push             = 1'b1;
						wr.data.command     = cmd_d;
						wr.data.address     = addr_d;
						wr.data.word_count  = cnt_d;
						wr.data.payload_len = len_q;
						phase_d = PH_HUNT;
						seen_d  = '0;
						len_d   = '0;
						cmd_d   = '0;
						addr_d  = '0;
						cnt_d   = '0;
					end
				end
				default: phase_d = PH_HUNT;
			endcase
		end
	end

	dufd_res_fifo u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.full   (queue_full),
		.res    (res)
	);

	a_push_in_data: assert property (@(posedge clk) disable iff (!arst_n)
		wr.push |-> phase_q == PH_DATA && take)
		else $error("result pushed outside payload phase");

	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> len_q != '0)
		else $error("payload phase with zero length");

	a_seen_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> seen_q < len_q)
		else $error("payload count ran past frame length");

	a_back_to_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		wr.push |=> phase_q == PH_HUNT && seen_q == '0)
		else $error("state not cleared after completed frame");

endmodule
